// ===== hdl/vapn_pkg.sv =====
`default_nettype none

package vapn_pkg;

	// Register map and codes.
	localparam logic       REG_NORM_MODE = 1'b0;
	localparam logic [1:0] MODE_PASS     = 2'd0;
	localparam logic [1:0] MODE_AMP      = 2'd1;
	localparam logic [1:0] MODE_PHASE    = 2'd2;
	localparam logic       CMD_SAMPLE    = 1'b0;
	localparam logic       CMD_WEIGHT    = 1'b1;
	localparam logic       KIND_SAMPLE   = 1'b0;
	localparam logic       KIND_WEIGHT   = 1'b1;

	// Accumulator limits.
	localparam logic [27:0] SUM_MAX   = 28'hFFFFFFF;
	localparam logic [10:0] COUNT_MAX = 11'd2047;

	// Iteration counts of the shared compare-subtract unit.
	localparam int ROOT_STEPS = 16;
	localparam int DIV_STEPS  = 17;

	// Operands of the shared arithmetic unit.
	typedef struct packed {
		logic [31:0] mul_a;
		logic [16:0] mul_b;
		logic [18:0] cs_a;
		logic [18:0] cs_b;
	} arith_req_t;

	// Results of the shared arithmetic unit.
	typedef struct packed {
		logic [48:0] prod;
		logic [18:0] cs_diff;
		logic        cs_ge;
	} arith_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/vapn_arith.sv =====
`default_nettype none

module vapn_arith (
	input  vapn_pkg::arith_req_t req,
	output vapn_pkg::arith_rsp_t rsp
);

	// Unsigned 32x17 multiplier and one 19-bit compare-subtract step.
	always_comb begin
		rsp.prod    = 49'(req.mul_a) * 49'(req.mul_b);
		rsp.cs_diff = req.cs_a - req.cs_b;
		rsp.cs_ge   = (req.cs_a >= req.cs_b);
	end

endmodule

`default_nettype wire

// ===== hdl/visibility_amp_phase_normalizer.sv =====
// Pass-through items and weights that are not rescaled go straight to the result state; an
// amplitude-only sample takes squares, root and rounding, a phase-only one then two divisions,
// and a rescaled weight a mean division and multiplies. The sequencer holds one item at a time,
// and the shared unit runs 16 square-root steps per root and 17 division steps per quotient.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) clears the mode, the accumulators and all handshake state.
`default_nettype none

module visibility_amp_phase_normalizer #(
	parameter int NUM_CORR = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [1:0]  corr_index,
	input  wire logic signed [15:0] sample_re,
	input  wire logic signed [15:0] sample_im,
	input  wire logic        sample_flagged,
	input  wire logic        row_flagged,
	input  wire logic [31:0] weight_in,
	// Output channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic signed [16:0] out_re,
	output logic signed [15:0] out_im,
	output logic      [31:0] weight_out
);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_SQ0  = 13'b0000000000010,
		S_SQ1  = 13'b0000000000100,
		S_SQ2  = 13'b0000000001000,
		S_ROOT = 13'b0000000010000,
		S_RND  = 13'b0000000100000,
		S_DIV  = 13'b0000001000000,
		S_DFIN = 13'b0000010000000,
		S_MUL0 = 13'b0000100000000,
		S_MUL1 = 13'b0001000000000,
		S_MUL2 = 13'b0010000000000,
		S_MUL3 = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		SEL_RE   = 2'd0,
		SEL_IM   = 2'd1,
		SEL_MEAN = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic [18:0] rem;
		logic [31:0] num;
		logic [16:0] den;
		logic        ovf;
	} div_init_t;

	// Start of a restoring division with a 17-bit quotient; a quotient that
	// would not fit is flagged up front.
	function automatic div_init_t div_init(input logic [31:0] n, input logic [16:0] d);
		div_init_t r;
		r.rem = {4'b0, n[31:17]};
		r.num = {n[16:0], 15'b0};
		r.den = d;
		r.ovf = ({2'b0, n[31:17]} >= d);
		return r;
	endfunction

	// Sign and saturation of one unit-magnitude part.
	function automatic logic signed [15:0] unit_part(input logic [16:0] q, input logic neg);
		logic signed [15:0] r;
		if (neg) begin
			r = (q > 17'd32768) ? 16'sh8000 : 16'(~q + 17'd1);
		end else begin
			r = (q > 17'd32767) ? 16'sh7FFF : 16'(q);
		end
		return r;
	endfunction

	state_t        state_q, state_d;
	div_sel_t      div_sel_q;
	logic [4:0]    cnt_q;
	logic [1:0]    norm_mode_q;
	logic          out_valid_q;
	logic [27:0]   sum_q [NUM_CORR];
	logic [10:0]   count_q [NUM_CORR];

	logic          cmd_q;
	logic [1:0]    idx_q;
	logic signed [15:0] re_q, im_q;
	logic [31:0]   w_q;
	logic signed [16:0] res_re_q;
	logic signed [15:0] res_im_q;
	logic [31:0]   res_w_q;
	logic [18:0]   rem_q;
	logic [16:0]   quo_q;
	logic [31:0]   num_q;
	logic [16:0]   den_q;
	logic          ovf_q;
	logic [16:0]   mag_q;
	logic [16:0]   mean_q;
	logic [48:0]   prod_q;
	logic [16:0]   p1hi_q;
	logic [66:0]   acc_q;

	vapn_pkg::arith_req_t req;
	vapn_pkg::arith_rsp_t rsp;

	logic          accept, load_out, proc_sample, w_scale, w_div, idx_ok_in, idx_ok_q;
	logic          cfg_wr;
	logic [27:0]   rd_sum;
	logic [10:0]   rd_cnt;
	logic [15:0]   abs_re, abs_im;
	logic [16:0]   mag_d, dq;
	logic [31:0]   mean_n;
	div_init_t     di_mean, di_re, di_im;
	logic [28:0]   sum_next;
	logic [66:0]   w_total;
	logic signed [15:0] up_re;

	vapn_arith u_arith (
		.req(req),
		.rsp(rsp)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == vapn_pkg::REG_NORM_MODE) ? {30'b0, norm_mode_q} : 32'b0;

	// Handshake and decode of the incoming item.
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign idx_ok_in = (int'(corr_index) < NUM_CORR);
	assign idx_ok_q  = (int'(idx_q) < NUM_CORR);

	always_comb begin
		rd_sum = 28'b0;
		rd_cnt = 11'b0;
		for (int e = 0; e < NUM_CORR; e++) begin
			if (int'(corr_index) == e) begin
				rd_sum = sum_q[e];
				rd_cnt = count_q[e];
			end
		end
	end

	assign proc_sample = (command == vapn_pkg::CMD_SAMPLE) && !sample_flagged && !row_flagged
		&& (norm_mode_q == vapn_pkg::MODE_AMP || norm_mode_q == vapn_pkg::MODE_PHASE)
		&& (sample_re != 16'sd0 || sample_im != 16'sd0);
	assign w_scale = (command == vapn_pkg::CMD_WEIGHT) && idx_ok_in
		&& (norm_mode_q == vapn_pkg::MODE_PHASE) && !row_flagged;
	assign w_div   = w_scale && (rd_cnt != 11'd0);

	// Operand preparation for the divisions.
	assign abs_re  = re_q[15] ? (~re_q + 16'd1) : re_q;
	assign abs_im  = im_q[15] ? (~im_q + 16'd1) : im_q;
	assign mag_d   = {1'b0, quo_q[15:0]} + 17'((rem_q > {3'b0, quo_q[15:0]}) ? 1 : 0);
	assign dq      = ovf_q ? 17'h1FFFF : quo_q;
	assign mean_n  = {3'b0, rd_sum, 1'b0} + {21'b0, rd_cnt};
	assign di_mean = div_init(mean_n, {5'b0, rd_cnt, 1'b0});
	assign di_re   = div_init({abs_re, 16'b0} + {15'b0, mag_d}, {mag_d[15:0], 1'b0});
	assign di_im   = div_init({abs_im, 16'b0} + {15'b0, mag_q}, {mag_q[15:0], 1'b0});
	assign w_total = acc_q + {prod_q[34:0], 32'b0};
	assign up_re   = unit_part(dq, re_q[15]);

	always_comb begin
		sum_next = 29'b0;
		for (int e = 0; e < NUM_CORR; e++) begin
			if (int'(idx_q) == e) begin
				sum_next = {1'b0, sum_q[e]} + {12'b0, mag_d};
			end
		end
	end

	// Operand selection for the shared unit.
	always_comb begin
		req = '0;
		case (state_q)
			S_SQ0: begin
				req.mul_a = {16'b0, abs_re};
				req.mul_b = {1'b0, abs_re};
			end
			S_SQ1: begin
				req.mul_a = {16'b0, abs_im};
				req.mul_b = {1'b0, abs_im};
			end
			S_ROOT: begin
				req.cs_a = {rem_q[16:0], num_q[31:30]};
				req.cs_b = {1'b0, quo_q[15:0], 2'b01};
			end
			S_DIV: begin
				req.cs_a = {1'b0, rem_q[16:0], num_q[31]};
				req.cs_b = {2'b0, den_q};
			end
			S_MUL0: begin
				req.mul_a = w_q;
				req.mul_b = mean_q;
			end
			S_MUL1: begin
				req.mul_a = prod_q[31:0];
				req.mul_b = mean_q;
			end
			S_MUL2: begin
				req.mul_a = {15'b0, p1hi_q};
				req.mul_b = mean_q;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (proc_sample) begin
						state_d = S_SQ0;
					end else if (w_div) begin
						state_d = S_DIV;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SQ0:  state_d = S_SQ1;
			S_SQ1:  state_d = S_SQ2;
			S_SQ2:  state_d = S_ROOT;
			S_ROOT: begin
				if (cnt_q == 5'(vapn_pkg::ROOT_STEPS - 1)) begin
					state_d = S_RND;
				end
			end
			S_RND: begin
				state_d = (norm_mode_q == vapn_pkg::MODE_AMP) ? S_DONE : S_DIV;
			end
			S_DIV: begin
				if (cnt_q == 5'(vapn_pkg::DIV_STEPS - 1)) begin
					state_d = S_DFIN;
				end
			end
			S_DFIN: begin
				case (div_sel_q)
					SEL_RE:   state_d = S_DIV;
					SEL_IM:   state_d = S_DONE;
					SEL_MEAN: state_d = S_MUL0;
					default:  state_d = S_DONE;
				endcase
			end
			S_MUL0: state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_sel_q   <= SEL_RE;
			cnt_q       <= 5'd0;
			norm_mode_q <= vapn_pkg::MODE_PASS;
			out_valid_q <= 1'b0;
			for (int e = 0; e < NUM_CORR; e++) begin
				sum_q[e]   <= 28'b0;
				count_q[e] <= 11'b0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr && paddr[2] == vapn_pkg::REG_NORM_MODE) begin
				norm_mode_q <= pwdata[1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != state_d) begin
				cnt_q <= 5'd0;
			end else if (state_q == S_ROOT || state_q == S_DIV) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (accept) begin
				div_sel_q <= w_div ? SEL_MEAN : SEL_RE;
			end else if (state_q == S_DFIN && div_sel_q == SEL_RE) begin
				div_sel_q <= SEL_IM;
			end
			// A weight transfer closes the row of its correlation.
			for (int e = 0; e < NUM_CORR; e++) begin
				if (accept && command == vapn_pkg::CMD_WEIGHT && int'(corr_index) == e) begin
					sum_q[e]   <= 28'b0;
					count_q[e] <= 11'b0;
				end
				if (state_q == S_RND && norm_mode_q == vapn_pkg::MODE_PHASE
					&& idx_ok_q && int'(idx_q) == e) begin
					sum_q[e] <= sum_next[28] ? vapn_pkg::SUM_MAX : sum_next[27:0];
					if (count_q[e] != vapn_pkg::COUNT_MAX) begin
						count_q[e] <= count_q[e] + 11'd1;
					end
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q    <= command;
					idx_q    <= corr_index;
					re_q     <= sample_re;
					im_q     <= sample_im;
					w_q      <= weight_in;
					if (command == vapn_pkg::CMD_SAMPLE) begin
						res_re_q <= {sample_re[15], sample_re};
						res_im_q <= sample_im;
						res_w_q  <= 32'd0;
					end else begin
						res_re_q <= 17'sd0;
						res_im_q <= 16'sd0;
						res_w_q  <= w_scale ? 32'd0 : weight_in;
					end
					rem_q <= di_mean.rem;
					num_q <= di_mean.num;
					den_q <= di_mean.den;
					ovf_q <= di_mean.ovf;
					quo_q <= 17'd0;
				end
			end
			S_SQ0: begin
				prod_q <= rsp.prod;
			end
			S_SQ1: begin
				prod_q <= rsp.prod;
				num_q  <= prod_q[31:0];
			end
			S_SQ2: begin
				num_q <= num_q + prod_q[31:0];
				rem_q <= 19'd0;
				quo_q <= 17'd0;
			end
			S_ROOT: begin
				rem_q <= rsp.cs_ge ? rsp.cs_diff : req.cs_a;
				quo_q <= {quo_q[15:0], rsp.cs_ge};
				num_q <= {num_q[29:0], 2'b00};
			end
			S_RND: begin
				mag_q <= mag_d;
				if (norm_mode_q == vapn_pkg::MODE_AMP) begin
					res_re_q <= mag_d;
					res_im_q <= 16'sd0;
				end
				rem_q <= di_re.rem;
				num_q <= di_re.num;
				den_q <= di_re.den;
				ovf_q <= di_re.ovf;
				quo_q <= 17'd0;
			end
			S_DIV: begin
				rem_q <= rsp.cs_ge ? rsp.cs_diff : req.cs_a;
				quo_q <= {quo_q[15:0], rsp.cs_ge};
				num_q <= {num_q[30:0], 1'b0};
			end
			S_DFIN: begin
				case (div_sel_q)
					SEL_RE: begin
						res_re_q <= {up_re[15], up_re};
						rem_q    <= di_im.rem;
						num_q    <= di_im.num;
						den_q    <= di_im.den;
						ovf_q    <= di_im.ovf;
						quo_q    <= 17'd0;
					end
					SEL_IM: begin
						res_im_q <= unit_part(dq, im_q[15]);
					end
					default: begin
						mean_q <= dq;
					end
				endcase
			end
			S_MUL0: begin
				prod_q <= rsp.prod;
			end
			S_MUL1: begin
				prod_q <= rsp.prod;
				p1hi_q <= prod_q[48:32];
			end
			S_MUL2: begin
				acc_q  <= {18'b0, prod_q} + (67'd1 << 29);
				prod_q <= rsp.prod;
			end
			S_MUL3: begin
				res_w_q <= (w_total[66:62] != 5'd0) ? 32'hFFFFFFFF : w_total[61:30];
			end
			default: begin
			end
		endcase
	end

	// Output register, loaded when it is empty or as the previous result leaves.
	always_ff @(posedge clk) begin
		if (load_out) begin
			result_kind <= cmd_q ? vapn_pkg::KIND_WEIGHT : vapn_pkg::KIND_SAMPLE;
			out_re      <= res_re_q;
			out_im      <= res_im_q;
			weight_out  <= res_w_q;
		end
	end

	// Every transfer leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after an input transfer");

	// Divisors are never zero while dividing.
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> den_q != 17'd0)
		else $error("division by zero in the shared unit");

	// A nonzero sample gives a nonzero floor root.
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RND |-> quo_q[15:0] != 16'd0)
		else $error("zero root for a processed sample");

	// Unit-magnitude quotients always fit the divider.
	a_unit_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DFIN && div_sel_q != SEL_MEAN) |-> !ovf_q)
		else $error("unit-part quotient overflowed");

	// A result is never dropped by a new load.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && state_q == S_DONE) |=> state_q == S_DONE)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic        command;
	logic [1:0]  corr_index;
	logic signed [15:0] sample_re, sample_im;
	logic        sample_flagged, row_flagged;
	logic [31:0] weight_in;
	logic        out_valid, out_ready;
	logic        result_kind;
	logic signed [16:0] out_re;
	logic signed [15:0] out_im;
	logic [31:0] weight_out;

	visibility_amp_phase_normalizer uut (.*);

	typedef struct packed {
		logic        command;
		logic [1:0]  corr_index;
		logic [15:0] sample_re;
		logic [15:0] sample_im;
		logic        sample_flagged;
		logic        row_flagged;
		logic [31:0] weight_in;
	} vis_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [16:0] out_re;
		logic [15:0] out_im;
		logic [31:0] weight_out;
	} vis_result_t;

	// Directed row: stimulus, mode, and an optional typed-in expectation.
	typedef struct {
		logic [1:0]  mode;
		vis_item_t   item;
		bit          has_golden;
		vis_result_t golden;
	} directed_row_t;

	vis_result_t pending_results[$];
	logic [27:0] mag_sum[4];
	logic [10:0] mag_count[4];
	logic [1:0]  cur_mode;
	int          fail_count;
	int          result_count;
	int          weight_results;
	bit          stall_long;
	bit          no_idle;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("visibility_amp_phase_normalizer test failed");
		$finish;
	end

	// Rounded integer square root.
	function automatic logic [31:0] root_round(input logic [63:0] s);
		logic [63:0] r, b, rem;
		r = 0;
		rem = s;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (rem > r) r = r + 1;
		return r[31:0];
	endfunction

	// One part of the unit-magnitude sample, rounded and saturated.
	function automatic logic [15:0] unit_of(input logic signed [15:0] part,
			input logic [31:0] mag);
		logic [63:0] n, q;
		n = (part < 0 ? 64'(-int'(part)) : 64'(int'(part))) * 64'd32768;
		q = (2 * n + mag) / (2 * 64'(mag));
		if (part < 0) return q > 32768 ? 16'h8000 : 16'(-int'(q));
		return q > 32767 ? 16'h7FFF : q[15:0];
	endfunction

	// Weight scaled by the squared mean magnitude.
	function automatic logic [31:0] rescale(input logic [31:0] w,
			input logic [27:0] sum, input logic [10:0] cnt);
		logic [63:0] mean, sq, t, acc;
		if (cnt == 0) return 32'd0;
		mean = (2 * 64'(sum) + cnt) / (2 * 64'(cnt));
		if (mean > 131071) mean = 131071;
		sq = mean * mean;
		t = 64'(w[15:0]) * sq + (64'd1 << 29);
		acc = (64'(w[31:16]) * sq + (t >> 16)) >> 14;
		return acc > 64'hFFFFFFFF ? 32'hFFFFFFFF : acc[31:0];
	endfunction

	// Predict one result and update the accumulators.
	function automatic vis_result_t normalize(input vis_item_t it);
		vis_result_t r;
		logic signed [15:0] re, im;
		logic [63:0] s;
		logic [31:0] mag;
		logic [28:0] ns;
		r = '0;
		re = it.sample_re;
		im = it.sample_im;
		if (it.command == vapn_pkg::CMD_WEIGHT) begin
			r.result_kind = vapn_pkg::KIND_WEIGHT;
			r.weight_out = it.weight_in;
			if (cur_mode == vapn_pkg::MODE_PHASE && !it.row_flagged)
				r.weight_out = rescale(it.weight_in, mag_sum[it.corr_index],
					mag_count[it.corr_index]);
			mag_sum[it.corr_index] = '0;
			mag_count[it.corr_index] = '0;
			return r;
		end
		r.result_kind = vapn_pkg::KIND_SAMPLE;
		r.out_re = 17'(re);
		r.out_im = im;
		if (!it.sample_flagged && !it.row_flagged &&
				(cur_mode == vapn_pkg::MODE_AMP || cur_mode == vapn_pkg::MODE_PHASE)) begin
			s = 64'(longint'(re) * re + longint'(im) * im);
			if (s != 0) begin
				mag = root_round(s);
				if (cur_mode == vapn_pkg::MODE_AMP) begin
					r.out_re = mag[16:0];
					r.out_im = '0;
				end else begin
					r.out_re = 17'(signed'(unit_of(re, mag)));
					r.out_im = unit_of(im, mag);
					ns = mag_sum[it.corr_index] + mag;
					mag_sum[it.corr_index] = ns > vapn_pkg::SUM_MAX ? vapn_pkg::SUM_MAX
						: ns[27:0];
					if (mag_count[it.corr_index] < vapn_pkg::COUNT_MAX)
						mag_count[it.corr_index]++;
				end
			end
		end
		return r;
	endfunction

	// APB write of the mode register; the model copy follows.
	task automatic write_mode(input logic [1:0] m);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = {vapn_pkg::REG_NORM_MODE, 2'b00};
		pwdata = 32'(m);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		cur_mode = m;
	endtask

	// Wait until every expected result has come, plus a margin.
	task automatic drain;
		int guard;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	// Offer one item, with random idle cycles before it.
	task automatic send_item(input vis_item_t it);
		while (!no_idle && $urandom_range(99) < 23) @(negedge clk);
		{command, corr_index, sample_re, sample_im, sample_flagged,
			row_flagged, weight_in} = it;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(normalize(it));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic vis_item_t random_item(input bit well_formed);
		vis_item_t it;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		it = raw[68:0];
		it.command = ($urandom_range(15) == 0) ? vapn_pkg::CMD_WEIGHT : vapn_pkg::CMD_SAMPLE;
		if (well_formed) begin
			it.sample_flagged = ($urandom_range(9) == 0);
			it.row_flagged = ($urandom_range(15) == 0);
			if ($urandom_range(7) == 0) it.sample_re = 16'sh8000;
			if ($urandom_range(7) == 0) it.sample_im = 16'sh7FFF;
			if ($urandom_range(20) == 0) begin
				it.sample_re = '0;
				it.sample_im = '0;
			end
		end
		return it;
	endfunction

	// Receiver: random stalls, one long hold-off, and the checks.
	initial begin
		vis_result_t got, want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_long) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				stall_long = 1'b0;
			end
			out_ready = no_idle ? 1'b1 : ($urandom_range(99) >= 23);
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = '{result_kind, out_re, out_im, weight_out};
				result_count++;
				if (result_kind == vapn_pkg::KIND_WEIGHT) weight_results++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected transfer %h", $time, got);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.result_kind !== want.result_kind) begin
						$display("%0t: result_kind expected %0d actual %0d", $time,
							want.result_kind, got.result_kind);
						fail_count++;
					end
					if (got.out_re !== want.out_re) begin
						$display("%0t: out_re expected %0d actual %0d", $time,
							signed'(want.out_re), signed'(got.out_re));
						fail_count++;
					end
					if (got.out_im !== want.out_im) begin
						$display("%0t: out_im expected %0d actual %0d", $time,
							signed'(want.out_im), signed'(got.out_im));
						fail_count++;
					end
					if (got.weight_out !== want.weight_out) begin
						$display("%0t: weight_out expected %h actual %h", $time,
							want.weight_out, got.weight_out);
						fail_count++;
					end
				end
			end
		end
	end

	// Stimulus.
	initial begin
		directed_row_t rows[$];
		directed_row_t dr;
		vis_result_t pred;
		logic [1:0] modes[6];
		int n;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; command = 0; corr_index = 0; sample_re = 0; sample_im = 0;
		sample_flagged = 0; row_flagged = 0; weight_in = 0;
		fail_count = 0; result_count = 0; weight_results = 0;
		stall_long = 0; no_idle = 0; cur_mode = vapn_pkg::MODE_PASS;
		for (int i = 0; i < 4; i++) begin
			mag_sum[i] = '0;
			mag_count[i] = '0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: pass-through extremes, a zero-count weight, magnitudes,
		// flags, phase rows with rescaled weights, and the unused mode.
		rows.push_back('{vapn_pkg::MODE_PASS,
			'{vapn_pkg::CMD_SAMPLE, 2'd0, 16'h8000, 16'h7FFF, 0, 0, 0},
			1, '{vapn_pkg::KIND_SAMPLE, 17'h18000, 16'h7FFF, 32'd0}});
		rows.push_back('{vapn_pkg::MODE_PASS,
			'{vapn_pkg::CMD_WEIGHT, 2'd3, 16'h0, 16'h0, 0, 0, 32'hFFFFFFFF},
			1, '{vapn_pkg::KIND_WEIGHT, 17'd0, 16'd0, 32'hFFFFFFFF}});
		rows.push_back('{vapn_pkg::MODE_AMP,
			'{vapn_pkg::CMD_SAMPLE, 2'd1, 16'h8000, 16'h8000, 0, 0, 0}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_AMP,
			'{vapn_pkg::CMD_SAMPLE, 2'd1, 16'd3, 16'd4, 0, 0, 0},
			1, '{vapn_pkg::KIND_SAMPLE, 17'd5, 16'd0, 32'd0}});
		rows.push_back('{vapn_pkg::MODE_AMP,
			'{vapn_pkg::CMD_SAMPLE, 2'd1, 16'd0, 16'd0, 0, 0, 0},
			1, '{vapn_pkg::KIND_SAMPLE, 17'd0, 16'd0, 32'd0}});
		rows.push_back('{vapn_pkg::MODE_AMP,
			'{vapn_pkg::CMD_SAMPLE, 2'd2, 16'd3, 16'd4, 1, 0, 0},
			1, '{vapn_pkg::KIND_SAMPLE, 17'd3, 16'd4, 32'd0}});
		rows.push_back('{vapn_pkg::MODE_AMP,
			'{vapn_pkg::CMD_WEIGHT, 2'd2, 16'd0, 16'd0, 0, 0, 32'h12345678},
			1, '{vapn_pkg::KIND_WEIGHT, 17'd0, 16'd0, 32'h12345678}});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_WEIGHT, 2'd0, 16'd0, 16'd0, 0, 0, 32'h00010000},
			1, '{vapn_pkg::KIND_WEIGHT, 17'd0, 16'd0, 32'd0}});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_SAMPLE, 2'd0, 16'h8000, 16'h0, 0, 0, 0}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_SAMPLE, 2'd0, 16'h7FFF, 16'h0, 0, 0, 0}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_SAMPLE, 2'd0, 16'h7FFF, 16'h8000, 0, 0, 0}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_SAMPLE, 2'd0, 16'd1, 16'hFFFF, 0, 0, 0}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_SAMPLE, 2'd0, 16'd5, 16'd5, 0, 1, 0},
			1, '{vapn_pkg::KIND_SAMPLE, 17'd5, 16'd5, 32'd0}});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_WEIGHT, 2'd0, 16'd0, 16'd0, 0, 0, 32'hFFFFFFFF}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_SAMPLE, 2'd1, 16'd1200, 16'h9000, 0, 0, 0}, 0, '0});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_WEIGHT, 2'd1, 16'd0, 16'd0, 0, 1, 32'h00020000},
			1, '{vapn_pkg::KIND_WEIGHT, 17'd0, 16'd0, 32'h00020000}});
		rows.push_back('{vapn_pkg::MODE_PHASE,
			'{vapn_pkg::CMD_WEIGHT, 2'd1, 16'd0, 16'd0, 0, 0, 32'h00020000},
			1, '{vapn_pkg::KIND_WEIGHT, 17'd0, 16'd0, 32'd0}});
		rows.push_back('{2'd3,
			'{vapn_pkg::CMD_SAMPLE, 2'd2, 16'd3, 16'd4, 0, 0, 0},
			1, '{vapn_pkg::KIND_SAMPLE, 17'd3, 16'd4, 32'd0}});
		rows.push_back('{2'd3,
			'{vapn_pkg::CMD_WEIGHT, 2'd2, 16'd0, 16'd0, 0, 0, 32'h0000FFFF},
			1, '{vapn_pkg::KIND_WEIGHT, 17'd0, 16'd0, 32'h0000FFFF}});

		foreach (rows[i]) begin
			dr = rows[i];
			if (dr.mode != cur_mode) begin
				drain();
				write_mode(dr.mode);
			end
			send_item(dr.item);
			if (dr.has_golden) begin
				pred = pending_results[$];
				if (pred !== dr.golden) begin
					$display("%0t: table row %0d expected %h predicted %h", $time, i,
						dr.golden, pred);
					fail_count++;
				end
			end
		end

		// Random phases across all modes; the long hold-off lands in the phase
		// mode, and one phase runs with no idling at all.
		modes = '{vapn_pkg::MODE_PHASE, vapn_pkg::MODE_AMP, vapn_pkg::MODE_PASS,
			vapn_pkg::MODE_PHASE, 2'd3, vapn_pkg::MODE_PHASE};
		foreach (modes[p]) begin
			drain();
			write_mode(modes[p]);
			no_idle = (p == 3);
			if (p == 0) stall_long = 1'b1;
			n = (p == 0 || p == 3 || p == 5) ? 250 : 100;
			for (int k = 0; k < n; k++)
				send_item(random_item($urandom_range(9) != 0));
		end
		no_idle = 0;
		drain();

		$display("Covered %0d results (%0d weights) over pass, amplitude, phase and mode three.",
			result_count, weight_results);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("visibility_amp_phase_normalizer test passed");
		end else begin
			$display("visibility_amp_phase_normalizer test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
